// ----- rtl/dwqps_pkg.sv -----
// ----------------------------------------------------------------------------
// dwqps_pkg
// types, codes and constants shared by the dual-wheel position servo
// ----------------------------------------------------------------------------
`default_nettype none

package dwqps_pkg;

    // position width default and its legal range is 16 to 64
    localparam int unsigned POSITION_WIDTH_DEFAULT = 32;

    localparam int unsigned COUNT_WIDTH     = 32;
    localparam int unsigned DEADBAND_WIDTH  = 8;
    localparam int unsigned SLOW_ZONE_WIDTH = 16;
    localparam int unsigned PULSE_WIDTH     = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 16;

    // request kinds
    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_TASK = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // task modes
    localparam logic [1:0] MODE_FORWARD = 2'd0;
    localparam logic [1:0] MODE_TURN    = 2'd1;
    localparam logic [1:0] MODE_SCAN    = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // duty codes
    localparam logic [1:0] DUTY_NORMAL = 2'd0;
    localparam logic [1:0] DUTY_TURN   = 2'd1;
    localparam logic [1:0] DUTY_SLOW   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOW_ZONE = 2'd1;

    // configuration reset values
    localparam logic [DEADBAND_WIDTH-1:0]  DEADBAND_RESET  = 8'd1;
    localparam logic [SLOW_ZONE_WIDTH-1:0] SLOW_ZONE_RESET = 16'd60;

    // encoder pin positions inside the pin level vector
    localparam int unsigned PIN_RIGHT_B = 0;
    localparam int unsigned PIN_RIGHT_A = 1;
    localparam int unsigned PIN_LEFT_B  = 2;
    localparam int unsigned PIN_LEFT_A  = 3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [1:0]             pin_select;
        logic                   pin_level;
        logic [1:0]             task_mode;
        logic [PULSE_WIDTH-1:0] pulse_count;
        logic                   turn_ccw;
    } item_t;

    typedef struct packed {
        logic                          left_enable;
        logic                          left_reverse;
        logic [1:0]                    left_duty;
        logic                          right_enable;
        logic                          right_reverse;
        logic [1:0]                    right_duty;
        logic                          task_done;
        logic signed [COUNT_WIDTH-1:0] left_count;
        logic signed [COUNT_WIDTH-1:0] right_count;
    } result_t;

    // drive state of one wheel
    typedef struct packed {
        logic [1:0] duty;
        logic       reverse;
        logic       enable;
    } drive_t;

    // quadrature decoder state
    typedef struct packed {
        logic [3:0] pins;
        logic [1:0] prev_right;
        logic [1:0] prev_left;
    } quad_state_t;

    // loop settings handed to each wheel
    typedef struct packed {
        logic [DEADBAND_WIDTH-1:0]  deadband;
        logic [SLOW_ZONE_WIDTH-1:0] slow_zone;
        logic                       turning;
    } servo_cfg_t;

    // previous quadrature state that makes a step count up
    function automatic logic [1:0] quad_expect(input logic [1:0] now);
        logic [1:0] prev;
        unique case (now)
            2'd0:    prev = 2'd1;
            2'd1:    prev = 2'd3;
            2'd2:    prev = 2'd0;
            default: prev = 2'd2;
        endcase
        return prev;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dwqps_quad_decoder.sv -----
// ----------------------------------------------------------------------------
// dwqps_quad_decoder
// pin level update and 4x quadrature step for both wheels
// ----------------------------------------------------------------------------
`default_nettype none

module dwqps_quad_decoder
    import dwqps_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
)
(
    input  quad_state_t               quad,
    input  logic [1:0]                pin_select,
    input  logic                      pin_level,
    input  logic [POSITION_WIDTH-1:0] pos_right,
    input  logic [POSITION_WIDTH-1:0] pos_left,
    output quad_state_t               quad_next,
    output logic [POSITION_WIDTH-1:0] pos_right_next,
    output logic [POSITION_WIDTH-1:0] pos_left_next
);

    logic [3:0] pins;
    logic [1:0] q_right;
    logic [1:0] q_left;
    logic       right_side;
    logic       step_up;
    logic       step_down;

    always_comb
    begin
        pins             = quad.pins;
        pins[pin_select] = pin_level;
        q_right          = {pins[PIN_RIGHT_B], pins[PIN_RIGHT_A]};
        q_left           = {pins[PIN_LEFT_B], pins[PIN_LEFT_A]};
        right_side       = !pin_select[1];
        step_up          = (quad_expect(q_right) == quad.prev_right);
        step_down        = (quad_expect(q_left) == quad.prev_left);

        quad_next      = quad;
        quad_next.pins = pins;
        pos_right_next = pos_right;
        pos_left_next  = pos_left;

        if (right_side)
        begin
            quad_next.prev_right = q_right;
            pos_right_next = step_up ? pos_right + POSITION_WIDTH'(1)
                                     : pos_right - POSITION_WIDTH'(1);
        end
        else
        begin
            // left wheel runs with inverted sense
            quad_next.prev_left = q_left;
            pos_left_next = step_down ? pos_left - POSITION_WIDTH'(1)
                                      : pos_left + POSITION_WIDTH'(1);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dwqps_servo_wheel.sv -----
// ----------------------------------------------------------------------------
// dwqps_servo_wheel
// one bang-bang pass for one wheel
// ----------------------------------------------------------------------------
`default_nettype none

module dwqps_servo_wheel
    import dwqps_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
)
(
    input  logic [POSITION_WIDTH-1:0] goal,
    input  logic [POSITION_WIDTH-1:0] pos,
    input  drive_t                    drive,
    input  servo_cfg_t                cfg,
    output drive_t                    drive_next,
    output logic                      arrived
);

    logic [POSITION_WIDTH-1:0] err;
    logic [POSITION_WIDTH-1:0] mag;
    logic                      neg;

    always_comb
    begin
        err = goal - pos;
        neg = err[POSITION_WIDTH-1];
        // most negative error folds to the sign weight on its own
        mag = neg ? (~err + POSITION_WIDTH'(1)) : err;

        drive_next = drive;
        arrived    = 1'b0;
        if (mag > POSITION_WIDTH'(cfg.deadband))
        begin
            drive_next.enable  = 1'b1;
            drive_next.reverse = neg;
            if (cfg.turning && (mag < POSITION_WIDTH'(cfg.slow_zone)))
            begin
                drive_next.duty = DUTY_SLOW;
            end
        end
        else
        begin
            drive_next.enable = 1'b0;
            arrived           = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dual_wheel_quadrature_position_servo_top.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_quadrature_position_servo_top
// two-wheel quadrature position servo with bang-bang drive control
// ----------------------------------------------------------------------------
// Each request is one of three kinds: an encoder pin edge, a new task or a
// control tick, and every request gives exactly one result that shows both
// motor drives, the done flag and both wheel positions as they stand after
// that request. The block takes one request per clock cycle for as long as
// results are taken; a request waits in the input register while one pass
// of the decoder and servo logic feeds the result register, which also
// updates the state, and the result then stays on the result port until it
// is taken. The deadband and slow zone registers are written through the cfg
// port, which is always ready, and should only be written while no request
// is in flight.
`default_nettype none

module dual_wheel_quadrature_position_servo_top
    import dwqps_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       item_valid,
    output logic                       item_stall,
    input  item_t                      item,
    // result channel
    output logic                       result_valid,
    input  logic                       result_stall,
    output result_t                    result,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DEADBAND_WIDTH-1:0]  deadband_reg;
    logic [SLOW_ZONE_WIDTH-1:0] slow_zone_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RESET;
            slow_zone_reg <= SLOW_ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEADBAND:  deadband_reg  <= cfg_data[DEADBAND_WIDTH-1:0];
                REG_SLOW_ZONE: slow_zone_reg <= cfg_data[SLOW_ZONE_WIDTH-1:0];
                default:       ; // writes to unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register and flow control
    // ------------------------------------------------------------------
    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;
    logic  result_valid_reg;
    logic  result_valid_next;
    logic  advance;

    // the held request moves on unless a finished result is stuck
    assign advance    = item_valid_reg && !(result_valid_reg && result_stall);
    assign item_stall = item_valid_reg && result_valid_reg && result_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_valid && !item_stall)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    // ------------------------------------------------------------------
    // servo state
    // ------------------------------------------------------------------
    quad_state_t               quad_reg;
    quad_state_t               quad_next;
    logic [POSITION_WIDTH-1:0] pos_right_reg;
    logic [POSITION_WIDTH-1:0] pos_right_next;
    logic [POSITION_WIDTH-1:0] pos_left_reg;
    logic [POSITION_WIDTH-1:0] pos_left_next;
    logic [POSITION_WIDTH-1:0] goal_right_reg;
    logic [POSITION_WIDTH-1:0] goal_right_next;
    logic [POSITION_WIDTH-1:0] goal_left_reg;
    logic [POSITION_WIDTH-1:0] goal_left_next;
    logic [1:0]                motion_mode_reg;
    logic [1:0]                motion_mode_next;
    logic [1:0]                wheel_done_reg;
    logic [1:0]                wheel_done_next;
    logic                      all_done_reg;
    logic                      all_done_next;
    drive_t                    left_drive_reg;
    drive_t                    left_drive_next;
    drive_t                    right_drive_reg;
    drive_t                    right_drive_next;
    result_t                   result_reg;
    result_t                   result_next;

    // decoder and wheel loop outputs
    quad_state_t               dec_quad;
    logic [POSITION_WIDTH-1:0] dec_pos_right;
    logic [POSITION_WIDTH-1:0] dec_pos_left;
    servo_cfg_t                servo_cfg;
    drive_t                    left_servo_drive;
    drive_t                    right_servo_drive;
    logic                      left_arrived;
    logic                      right_arrived;

    // task arithmetic
    logic [POSITION_WIDTH-1:0] pulses;
    logic                      task_turn;
    logic [1:0]                task_duty;

    dwqps_quad_decoder #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_quad_decoder (
        .quad           (quad_reg),
        .pin_select     (item_reg.pin_select),
        .pin_level      (item_reg.pin_level),
        .pos_right      (pos_right_reg),
        .pos_left       (pos_left_reg),
        .quad_next      (dec_quad),
        .pos_right_next (dec_pos_right),
        .pos_left_next  (dec_pos_left)
    );

    // slow duty only applies in turn modes
    assign servo_cfg.deadband  = deadband_reg;
    assign servo_cfg.slow_zone = slow_zone_reg;
    assign servo_cfg.turning   = (motion_mode_reg != MODE_FORWARD);

    dwqps_servo_wheel #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_servo_left (
        .goal       (goal_left_reg),
        .pos        (pos_left_reg),
        .drive      (left_drive_reg),
        .cfg        (servo_cfg),
        .drive_next (left_servo_drive),
        .arrived    (left_arrived)
    );

    dwqps_servo_wheel #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_servo_right (
        .goal       (goal_right_reg),
        .pos        (pos_right_reg),
        .drive      (right_drive_reg),
        .cfg        (servo_cfg),
        .drive_next (right_servo_drive),
        .arrived    (right_arrived)
    );

    assign pulses    = POSITION_WIDTH'(item_reg.pulse_count);
    assign task_turn = (item_reg.task_mode != MODE_FORWARD);
    assign task_duty = task_turn ? DUTY_TURN : DUTY_NORMAL;

    // next state for the request held in the input register
    always_comb
    begin
        quad_next        = quad_reg;
        pos_right_next   = pos_right_reg;
        pos_left_next    = pos_left_reg;
        goal_right_next  = goal_right_reg;
        goal_left_next   = goal_left_reg;
        motion_mode_next = motion_mode_reg;
        wheel_done_next  = wheel_done_reg;
        all_done_next    = all_done_reg;
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;

        unique case (item_reg.kind)
            KIND_EDGE:
            begin
                quad_next      = dec_quad;
                pos_right_next = dec_pos_right;
                pos_left_next  = dec_pos_left;
            end
            KIND_TASK:
            begin
                // an unknown task mode leaves everything as it is
                if (item_reg.task_mode != MODE_INVALID)
                begin
                    if (!task_turn)
                    begin
                        goal_right_next = pos_right_reg + pulses;
                        goal_left_next  = pos_left_reg + pulses;
                    end
                    else if (item_reg.turn_ccw)
                    begin
                        goal_right_next = pos_right_reg + pulses;
                        goal_left_next  = pos_left_reg - pulses;
                    end
                    else
                    begin
                        goal_right_next = pos_right_reg - pulses;
                        goal_left_next  = pos_left_reg + pulses;
                    end
                    motion_mode_next      = item_reg.task_mode;
                    wheel_done_next       = 2'b00;
                    all_done_next         = 1'b0;
                    // enables and directions carry over into the new task
                    left_drive_next.duty  = task_duty;
                    right_drive_next.duty = task_duty;
                end
            end
            KIND_TICK:
            begin
                // ticks do nothing once both wheels have arrived
                if (!all_done_reg)
                begin
                    if (!wheel_done_reg[0])
                    begin
                        left_drive_next    = left_servo_drive;
                        wheel_done_next[0] = left_arrived;
                    end
                    if (!wheel_done_reg[1])
                    begin
                        right_drive_next   = right_servo_drive;
                        wheel_done_next[1] = right_arrived;
                    end
                    all_done_next = &wheel_done_next;
                end
            end
            default:
            begin
                // unused kind, outputs show the current state
            end
        endcase

        result_next.left_enable   = left_drive_next.enable;
        result_next.left_reverse  = left_drive_next.reverse;
        result_next.left_duty     = left_drive_next.duty;
        result_next.right_enable  = right_drive_next.enable;
        result_next.right_reverse = right_drive_next.reverse;
        result_next.right_duty    = right_drive_next.duty;
        result_next.task_done     = all_done_next;
        // positions are sign extended or cut down to the report width
        result_next.left_count    = COUNT_WIDTH'(signed'(pos_left_next));
        result_next.right_count   = COUNT_WIDTH'(signed'(pos_right_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg        <= '0;
            pos_right_reg   <= '0;
            pos_left_reg    <= '0;
            goal_right_reg  <= '0;
            goal_left_reg   <= '0;
            motion_mode_reg <= MODE_FORWARD;
            wheel_done_reg  <= 2'b11;
            all_done_reg    <= 1'b1;
            left_drive_reg  <= '{duty: DUTY_NORMAL, reverse: 1'b0, enable: 1'b0};
            right_drive_reg <= '{duty: DUTY_NORMAL, reverse: 1'b0, enable: 1'b0};
        end
        else if (advance)
        begin
            quad_reg        <= quad_next;
            pos_right_reg   <= pos_right_next;
            pos_left_reg    <= pos_left_next;
            goal_right_reg  <= goal_right_next;
            goal_left_reg   <= goal_left_next;
            motion_mode_reg <= motion_mode_next;
            wheel_done_reg  <= wheel_done_next;
            all_done_reg    <= all_done_next;
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
        end
    end

    // result register, loaded together with the state
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- rtl/dwqps_checker.sv -----
// ----------------------------------------------------------------------------
// dwqps_checker
// port level checks for the dual-wheel position servo
// ----------------------------------------------------------------------------
`default_nettype none

module dwqps_checker
    import dwqps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic                          seen_reg;
    logic signed [COUNT_WIDTH-1:0] last_left_reg;
    logic signed [COUNT_WIDTH-1:0] last_right_reg;
    logic                          left_moved;
    logic                          right_moved;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end
        else if (result_valid && !result_stall)
        begin
            seen_reg       <= 1'b1;
            last_left_reg  <= result.left_count;
            last_right_reg <= result.right_count;
        end
    end

    assign left_moved  = (result.left_count != last_left_reg);
    assign right_moved = (result.right_count != last_right_reg);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // requests back up only behind a stuck result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("request stalled with the result side free");

    // a finished task leaves both motors off
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.task_done |-> !result.left_enable && !result.right_enable)
        else $error("motor enabled while task reported done");

    // one request moves at most one wheel
    a_one_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_reg |-> !(left_moved && right_moved))
        else $error("both wheel counts changed on one request");

endmodule

bind dual_wheel_quadrature_position_servo_top dwqps_checker u_dwqps_checker (.*);

`default_nettype wire
